// ===== hdl/text_console_char_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text console char writer assertion macros
// checks on the clock, TCCW_CHECK off while reset is held (TCCW_CHECK_ALL is not), silent in synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCCW_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TCCW_CHECK_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TCCW_CHECK(lbl, prop, msg)
`define TCCW_CHECK_ALL(lbl, prop, msg)
`endif

`endif

// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// types and constants of the text console char writer
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [7:0]  CH_NL  = 8'd10;
    localparam logic [7:0]  CH_TAB = 8'd9;
    localparam logic [7:0]  CH_BS  = 8'd8;
    localparam logic [7:0]  CH_SPACE = 8'd32;
    localparam logic [7:0]  ATTR_RESET = 8'd15;

    // geometry in cells (two bytes each)
    localparam logic [14:0] LINE_CELLS = 15'd80;
    localparam logic [14:0] BUF_CELLS  = 15'd16384;
    localparam logic [15:0] VIEW_CELLS = 16'd2000;
    // reciprocal of 5 for the divide by 80, exact for quotients of 11-bit inputs
    localparam logic [21:0] RECIP5     = 22'd1639;

    typedef enum logic {
        REQ_PUT = 1'b0,
        REQ_SET = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_SET    = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_req       req_type;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [7:0] row;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [13:0] cell_index;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [14:0] cursor_cell;
        logic [13:0] start_cell;
        logic        in_range;
        logic        last;
    } t_out_beat;

    // what one request does: cell writes first, then one closing beat
    typedef struct packed {
        logic [2:0]  n_writes;
        t_kind       fin_kind;
        logic        commit;
        logic [14:0] cursor;
        logic [14:0] view;
        logic [13:0] wr_base;
        logic [7:0]  wr_char;
        logic        in_range;
    } t_plan;

endpackage

// ===== hdl/tccw_step.sv =====
// ----------------------------------------------------------------------------
// tccw_step
// decodes one request against the cursor and view registers into a plan
// ----------------------------------------------------------------------------
module tccw_step (
    input  tccw_pkg::t_in_beat i_item,
    input  logic [14:0]        i_cursor,
    input  logic [14:0]        i_view,
    output tccw_pkg::t_plan    o_plan
);
    import tccw_pkg::*;

    logic [10:0] div_in;
    logic [21:0] div_prod;
    logic [8:0]  line_idx;
    logic [14:0] line_base;
    logic [6:0]  col;
    logic [8:0]  new_line;
    logic [14:0] new_cursor;
    logic [14:0] line_start;
    logic [15:0] view_limit;
    logic        scroll;
    logic [14:0] set_cell;
    logic [14:0] tab_room;

    // cursor / 80 = (cursor / 16) / 5
    assign div_in    = i_cursor[14:4];
    assign div_prod  = 22'(div_in) * RECIP5;
    assign line_idx  = div_prod[21:13];
    assign line_base = 15'(line_idx) * LINE_CELLS;
    assign col       = 7'(i_cursor - line_base);

    assign set_cell  = 15'(i_item.row) * LINE_CELLS + 15'(i_item.column);
    assign tab_room  = BUF_CELLS - i_cursor;

    always_comb begin
        case (i_item.char_code)
            CH_NL: begin
                new_cursor = line_base + LINE_CELLS;
                new_line   = line_idx + 9'd1;
            end
            CH_TAB: begin
                new_cursor = i_cursor + 15'd4;
                new_line   = (col >= 7'd76) ? line_idx + 9'd1 : line_idx;
            end
            CH_BS: begin
                new_cursor = i_cursor - 15'd1;
                new_line   = (col == 7'd0) ? line_idx - 9'd1 : line_idx;
            end
            default: begin
                new_cursor = i_cursor + 15'd1;
                new_line   = (col == 7'd79) ? line_idx + 9'd1 : line_idx;
            end
        endcase
    end

    assign line_start = 15'(new_line) * LINE_CELLS;
    assign view_limit = 16'(i_view) + VIEW_CELLS;
    assign scroll     = 16'(line_start) >= view_limit;

    always_comb begin
        o_plan          = '0;
        o_plan.wr_base  = i_cursor[13:0];
        o_plan.view     = i_view;
        o_plan.fin_kind = KIND_REJECT;
        if (i_item.req_type == REQ_SET) begin
            o_plan.fin_kind = KIND_SET;
            o_plan.commit   = 1'b1;
            o_plan.cursor   = set_cell;
            o_plan.in_range = set_cell < BUF_CELLS;
        end else if (i_cursor >= BUF_CELLS - 15'd1) begin
            o_plan.fin_kind = KIND_REJECT;
        end else if (i_item.char_code == CH_BS && i_cursor == 15'd0) begin
            o_plan.fin_kind = KIND_REJECT;
        end else begin
            o_plan.fin_kind = KIND_UPDATE;
            o_plan.commit   = 1'b1;
            o_plan.cursor   = new_cursor;
            o_plan.view     = scroll ? i_view + LINE_CELLS : i_view;
            case (i_item.char_code)
                CH_NL, CH_BS: begin
                    o_plan.n_writes = 3'd0;
                end
                CH_TAB: begin
                    // tab cells past the buffer end are dropped
                    o_plan.n_writes = (tab_room < 15'd4) ? tab_room[2:0] : 3'd4;
                    o_plan.wr_char  = CH_SPACE;
                end
                default: begin
                    o_plan.n_writes = 3'd1;
                    o_plan.wr_char  = i_item.char_code;
                end
            endcase
        end
    end

endmodule

// ===== hdl/text_console_char_writer.sv =====
// the request is held in the item register, each result beat in the output register
// throughput: one result beat per cycle while the output is not stalled; a request
//   has 1 to 5 results (a tab the most), issued through the single result register
// the next request is taken in the cycle its closing beat is issued
// reset (synchronous, active low) clears cursor and view, sets the attribute to 15
// ----------------------------------------------------------------------------
// text_console_char_writer
// 80-column text console: cell writes, cursor moves, one-line scrolling
// ----------------------------------------------------------------------------
`include "text_console_char_writer_assert.svh"

module text_console_char_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tccw_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tccw_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import tccw_pkg::*;

    logic        r_item_v, n_item_v;
    t_in_beat    r_item, n_item;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_v, n_out_v;
    t_out_beat   r_out, n_out;
    logic [7:0]  r_attr, n_attr;
    logic [14:0] r_cursor, n_cursor;
    logic [14:0] r_view, n_view;

    t_plan       plan;
    t_out_beat   beat;
    logic        emit_ok;
    logic        is_fin;
    logic        done;
    logic        accept;

    tccw_step u_step (
        .i_item   (r_item),
        .i_cursor (r_cursor),
        .i_view   (r_view),
        .o_plan   (plan)
    );

    assign emit_ok    = r_item_v && (!r_out_v || !i_out_stall);
    assign is_fin     = r_idx == plan.n_writes;
    assign done       = emit_ok && is_fin;
    assign o_in_stall = r_item_v && !done;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        beat = '0;
        if (!is_fin) begin
            beat.kind       = KIND_CELL;
            beat.cell_index = plan.wr_base + 14'(r_idx);
            beat.cell_char  = plan.wr_char;
            beat.cell_attr  = r_attr;
        end else begin
            beat.kind = plan.fin_kind;
            beat.last = 1'b1;
            if (plan.fin_kind == KIND_UPDATE || plan.fin_kind == KIND_SET) begin
                beat.cursor_cell = plan.cursor;
                beat.start_cell  = plan.view[13:0];
                beat.in_range    = plan.in_range;
            end
        end
    end

    always_comb begin
        n_item_v = r_item_v;
        n_item   = r_item;
        n_idx    = r_idx;
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_attr   = r_attr;
        n_cursor = r_cursor;
        n_view   = r_view;

        if (emit_ok) begin
            n_out_v = 1'b1;
            n_out   = beat;
            n_idx   = r_idx + 3'd1;
        end else if (!i_out_stall) begin
            n_out_v = 1'b0;
        end

        if (done) begin
            n_item_v = 1'b0;
            n_idx    = 3'd0;
            if (plan.commit) begin
                n_cursor = plan.cursor;
                n_view   = plan.view;
            end
        end

        if (accept) begin
            n_item_v = 1'b1;
            n_item   = i_in_data;
        end

        if (i_cfg_valid) begin
            n_attr = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_v <= 1'b0;
            r_idx    <= 3'd0;
            r_out_v  <= 1'b0;
            r_attr   <= ATTR_RESET;
            r_cursor <= 15'd0;
            r_view   <= 15'd0;
        end else begin
            r_item_v <= n_item_v;
            r_idx    <= n_idx;
            r_out_v  <= n_out_v;
            r_attr   <= n_attr;
            r_cursor <= n_cursor;
            r_view   <= n_view;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // only cell writes continue a request, every other beat closes it
    `TCCW_CHECK(a_last_kind, o_out_valid |-> ((o_out_data.kind == KIND_CELL) != o_out_data.last), "last flag does not match beat kind")
    // the beat counter never runs past the closing beat
    `TCCW_CHECK(a_idx_bound, r_item_v |-> (r_idx <= plan.n_writes), "result counter overran the plan")
    // a new request enters only when the held one is absent or closing
    `TCCW_CHECK(a_take_free, (i_in_valid && !o_in_stall) |-> (!r_item_v || done), "request taken over a busy one")
    // the view only ever moves down by one line
    `TCCW_CHECK(a_view_step, ($past(i_rst_n) && r_view != $past(r_view)) |-> (r_view == 15'($past(r_view) + LINE_CELLS)), "view moved by other than one line")
    // a cursor move is always reported by a closing beat
    `TCCW_CHECK_ALL(a_cursor_beat, (i_rst_n && r_item_v && plan.commit && done) |=> (r_out_v && r_out.last), "cursor moved without a closing beat")

endmodule

// ===== sim/tb_text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// self-checking bench for the 80-column text console writer: a directed run
// through the corner cases (rejects, scrolling, tabs cut at the buffer end,
// out of range cursor sets), then random traffic in phases with idle and
// stall pressure on both channels and a new attribute in each phase
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
    import tccw_pkg::*;

    localparam int unsigned COLS        = 32'(LINE_CELLS);
    localparam int unsigned LINE_BYTES  = 2 * LINE_CELLS;
    localparam int unsigned BUF_BYTES   = 2 * BUF_CELLS;
    localparam int unsigned VIEW_BYTES  = 2 * VIEW_CELLS;
    localparam int          WATCHDOG    = 2000;
    localparam int          REPORT_MAX  = 10;
    localparam int          PHASE_ITEMS = 62;

    class console_scoreboard;
        t_out_beat   expected_beats[$];
        logic [7:0]  attr;
        int unsigned cursor_off;
        int unsigned view_off;
        int          errors;

        function new();
            attr       = ATTR_RESET;
            cursor_off = 0;
            view_off   = 0;
            errors     = 0;
        endfunction

        function void set_attr(logic [7:0] value);
            attr = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_cell(int unsigned off, logic [7:0] ch);
            t_out_beat b;
            b            = '0;
            b.kind       = KIND_CELL;
            b.cell_index = off[14:1];
            b.cell_char  = ch;
            b.cell_attr  = attr;
            expected_beats.push_back(b);
        endfunction

        function void push_closing(t_kind k);
            t_out_beat b;
            b      = '0;
            b.kind = k;
            b.last = 1'b1;
            if (k != KIND_REJECT) begin
                b.cursor_cell = cursor_off[15:1];
                b.start_cell  = view_off[14:1];
            end
            if (k == KIND_SET) begin
                b.in_range = (cursor_off < BUF_BYTES);
            end
            expected_beats.push_back(b);
        endfunction

        // works out every beat that one request produces
        function void note_request(t_in_beat req);
            int unsigned pos;
            int unsigned col;
            int unsigned row;
            int unsigned line;
            pos = cursor_off;
            col = 32'(req.column);
            row = 32'(req.row);
            if (req.req_type == REQ_SET) begin
                // stored even when past the buffer
                cursor_off = ((col + row * COLS) * 2) & 16'hFFFF;
                push_closing(KIND_SET);
                return;
            end
            if (pos + 2 >= BUF_BYTES) begin
                push_closing(KIND_REJECT);
                return;
            end
            case (req.char_code)
                CH_NL: begin
                    pos = (pos / LINE_BYTES + 1) * LINE_BYTES;
                end
                CH_TAB: begin
                    // cells past the buffer end are dropped, cursor still moves
                    for (int i = 0; i < 4; i++) begin
                        if (pos + 2 * i < BUF_BYTES) begin
                            push_cell(pos + 2 * i, CH_SPACE);
                        end
                    end
                    pos += 8;
                end
                CH_BS: begin
                    if (pos < 2) begin
                        push_closing(KIND_REJECT);
                        return;
                    end
                    pos -= 2;
                end
                default: begin
                    push_cell(pos, req.char_code);
                    pos += 2;
                end
            endcase
            pos  &= 16'hFFFF;
            line  = (pos / LINE_BYTES) * LINE_BYTES;
            if (line >= view_off + VIEW_BYTES) begin
                view_off = (view_off + LINE_BYTES) & 16'hFFFF;
            end
            cursor_off = pos;
            push_closing(KIND_UPDATE);
        endfunction

        function string beat_text(t_out_beat b);
            return $sformatf({"kind=%0d cell=%0d char=%02h attr=%02h ",
                              "cursor=%0d start=%0d in_range=%0b last=%0b"},
                             b.kind, b.cell_index, b.cell_char, b.cell_attr,
                             b.cursor_cell, b.start_cell, b.in_range, b.last);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("unexpected result beat: %s", beat_text(got));
                end
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.cell_index !== want.cell_index ||
                got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                got.cursor_cell !== want.cursor_cell || got.start_cell !== want.start_cell ||
                got.in_range !== want.in_range || got.last !== want.last) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("mismatch at %0t, expected %s", $realtime, beat_text(want));
                    $display("                 actual   %s", beat_text(got));
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [7:0] i_cfg_data;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;

    console_scoreboard console_sb = new();

    text_console_char_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                console_sb.note_request(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                console_sb.check_beat(o_out_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic t_in_beat put_req(logic [7:0] ch);
        t_in_beat r;
        r.req_type  = REQ_PUT;
        r.char_code = ch;
        r.column    = 7'($urandom_range(0, 127));
        r.row       = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic t_in_beat set_req(logic [6:0] col, logic [7:0] row);
        t_in_beat r;
        r.req_type  = REQ_SET;
        r.char_code = 8'($urandom_range(0, 255));
        r.column    = col;
        r.row       = row;
        return r;
    endfunction

    function automatic t_in_beat random_req();
        int unsigned pick;
        logic [6:0]  col;
        logic [7:0]  row;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 79));
            case ($urandom_range(0, 7))
                0:       row = 8'($urandom_range(0, 255));
                1, 2:    row = 8'($urandom_range(200, 204));   // close to the buffer end
                default: row = 8'($urandom_range(0, 30));
            endcase
            return set_req(col, row);
        end
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            return put_req(CH_NL);
        end else if (pick < 22) begin
            return put_req(CH_TAB);
        end else if (pick < 32) begin
            return put_req(CH_BS);
        end else if (pick < 82) begin
            return put_req(8'($urandom_range(32, 126)));
        end
        return put_req(8'($urandom_range(0, 255)));
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_req(t_in_beat req);
        while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (console_sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        console_sb.set_attr(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, attribute still at its reset value
        send_req(put_req(CH_BS));          // backspace at the very start
        send_req(put_req(8'h00));
        send_req(put_req(8'hFF));
        send_req(put_req(CH_BS));
        send_req(put_req(CH_TAB));
        send_req(put_req(CH_NL));
        send_req(put_req(8'h41));
        send_req(set_req(7'd79, 8'd24));
        send_req(put_req(8'h5A));          // wraps to line 25, view scrolls
        send_req(set_req(7'd0, 8'd0));
        send_req(put_req(8'h61));          // cursor above the view, no scroll
        send_req(set_req(7'd79, 8'd25));
        send_req(put_req(CH_NL));          // newline into a scroll
        send_req(set_req(7'd62, 8'd204));  // last two cells of the buffer
        send_req(put_req(CH_TAB));         // half the tab falls off the end
        send_req(put_req(8'h78));
        send_req(set_req(7'd62, 8'd204));
        send_req(put_req(8'h71));
        send_req(put_req(8'h72));          // no room left
        send_req(set_req(7'd127, 8'd255));
        send_req(put_req(8'h20));
        send_req(set_req(7'd79, 8'd204));
        send_req(set_req(7'd0, 8'd0));
        send_req(put_req(8'h7F));
        wait_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                    write_attr(8'hFF);
                end
                1: begin
                    send_gap_pct = 68;
                    stall_pct    = 0;
                    write_attr(8'h00);
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 68;
                    write_attr(8'($urandom_range(1, 254)));
                end
                default: begin
                    send_gap_pct = 30;
                    stall_pct    = 30;
                    write_attr(8'($urandom_range(0, 255)));
                end
            endcase
            repeat (PHASE_ITEMS) send_req(random_req());
            wait_drain();
        end

        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (console_sb.errors == 0 && console_sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
